[design/tbeq_pkg.sv]
// shared types, constants and helpers of the three band equalizer
package tbeq_pkg;

  localparam int NUM_BANDS    = 3;
  localparam int MAX_CHANNELS = 2;
  localparam int NCOEF        = NUM_BANDS * 5;
  localparam int RAMP_LOG2    = 8;
  localparam int RAMP_SAMPLES = 1 << RAMP_LOG2;
  localparam int RAMP_W       = RAMP_LOG2 + 1;

  localparam int COEF_AW   = 6;
  localparam int COEF_SETS = 4;
  localparam int COEF_D    = 1 << COEF_AW;
  localparam int HIST_AW   = 5;
  localparam int HIST_D    = 1 << HIST_AW;
  localparam int DATA_W    = 24;
  localparam int ACC_W     = 51;

  localparam logic signed [DATA_W-1:0] ONE_Q20 = 24'sh100000;
  localparam logic signed [DATA_W-1:0] SMAX    = 24'sh7FFFFF;
  localparam logic signed [DATA_W-1:0] SMIN    = 24'sh800000;

  typedef enum logic [1:0] {
    OP_FILTER = 2'd0,
    OP_LOAD   = 2'd1,
    OP_COMMIT = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    SET_ACTIVE = 2'd0,
    SET_STAGED = 2'd1,
    SET_TARGET = 2'd2,
    SET_START  = 2'd3
  } cset_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COPY_A,
    ST_COPY_S,
    ST_SNAP,
    ST_RAMP,
    ST_FILT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [0:0]         channel;
    logic signed [23:0] sample_in;
    logic [1:0]         band;
    logic [2:0]         coeff_index;
    logic signed [23:0] coeff_value;
  } in_t;

  typedef struct packed {
    logic signed [23:0] sample_out;
    logic [0:0]         channel_out;
  } out_t;

  // flat coefficient index of band and slot
  function automatic logic [3:0] coef_idx(input logic [1:0] band, input logic [2:0] slot);
    logic [3:0] r;
    r = 4'(band) * 4'd5 + 4'(slot);
    return r;
  endfunction

  // true where the identity set holds one (b0 of each band)
  function automatic logic is_b0(input logic [3:0] idx);
    logic r;
    r = 1'b0;
    for (int b = 0; b < NUM_BANDS; b++) begin
      if (idx == 4'(b * 5)) r = 1'b1;
    end
    return r;
  endfunction

endpackage

[design/tbeq_ram.sv]
// generic one write, one read ram with registered read data
module tbeq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // storage and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/three_band_biquad_eq_ramped.sv]
// top level of the three band biquad equalizer with ramped coefficients
//
// Input words carry an op: filter a sample, load one staged coefficient, or
// commit the staged set. A commit starts a 256-step linear ramp from the
// current set to the staged one; each channel-0 sample advances it by one
// step before filtering, and the last step lands exactly on the target.
// Filtering runs three direct-form-I biquads in cascade per channel, one
// shared 25x25 multiplier, with coefficients and history held in two rams.
// A load writes one staged word; a commit runs two copy passes (active to
// start, staged to target). A sample first takes a ramp step over all
// coefficients, or the final snap, while a ramp runs; each band then runs
// five products through the multiplier and four history writes on the
// single ram write port. One word is in work at a time.
// After reset a clearing pass loads identity coefficients and zero
// history; in_stall is high during it. A result waits in the output
// register while out_stall is high; the block keeps taking loads and
// commits meanwhile, and a finished sample waits until the register frees.
module three_band_biquad_eq_ramped
  import tbeq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  state_t state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic [1:0] band_r, band_nxt;
  logic [0:0] ch_r, ch_nxt;
  logic signed [DATA_W-1:0] x_r, x_nxt;
  logic signed [DATA_W-1:0] y_r, y_nxt;
  logic signed [DATA_W-1:0] h0_r, h0_nxt;
  logic signed [DATA_W-1:0] h2_r, h2_nxt;
  logic signed [DATA_W-1:0] tgt_r, tgt_nxt;
  logic signed [DATA_W-1:0] start_r, start_nxt;
  logic signed [49:0] mul_r, mul_nxt;
  logic neg_r, neg_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [RAMP_W-1:0] ramp_left_r, ramp_left_nxt;
  logic out_valid_r, out_valid_nxt;
  out_t out_r, out_nxt;

  logic c_we, h_we;
  logic [COEF_AW-1:0] c_waddr, c_raddr;
  logic [HIST_AW-1:0] h_waddr, h_raddr;
  logic [DATA_W-1:0] c_wdata, c_rdata, h_wdata, h_rdata;

  logic signed [24:0] mul_a, mul_b;
  logic signed [49:0] prod;
  logic signed [ACC_W-1:0] rnd;
  logic signed [30:0] q;
  logic signed [DATA_W-1:0] y_sat;
  logic [RAMP_W-1:0] ramp_k;
  logic [RAMP_W-1:0] ramp_dec;
  logic [3:0] cpy_idx;
  cset_t cpy_src, cpy_dst;

  // coefficient sets: {set, index}
  tbeq_ram #(.WIDTH(DATA_W), .DEPTH(COEF_D)) u_coef_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  // filter history: {channel, band, x1 x2 y1 y2}
  tbeq_ram #(.WIDTH(DATA_W), .DEPTH(HIST_D)) u_hist_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  // shared multiplier
  assign prod = mul_a * mul_b;

  // round half up, shift to q1.23 and saturate
  assign rnd   = acc_r + ACC_W'(1 <<< 19);
  assign q     = 31'(rnd >>> 20);
  assign y_sat = (q > 31'(SMAX)) ? SMAX : (q < 31'(SMIN)) ? SMIN : DATA_W'(q);

  assign ramp_k   = RAMP_W'(RAMP_SAMPLES) - ramp_left_r;
  assign ramp_dec = ramp_left_r - RAMP_W'(1);
  assign cpy_idx  = cnt_r[3:0] - 4'd1;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // copy pass source and destination sets
  always_comb begin
    case (state_r)
      ST_COPY_A: begin cpy_src = SET_ACTIVE; cpy_dst = SET_START;  end
      ST_COPY_S: begin cpy_src = SET_STAGED; cpy_dst = SET_TARGET; end
      ST_SNAP:   begin cpy_src = SET_TARGET; cpy_dst = SET_ACTIVE; end
      default:   begin cpy_src = SET_ACTIVE; cpy_dst = SET_ACTIVE; end
    endcase
  end

  // sequencer: next state, datapath and ram control
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ph_nxt        = ph_r;
    band_nxt      = band_r;
    ch_nxt        = ch_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    h0_nxt        = h0_r;
    h2_nxt        = h2_r;
    tgt_nxt       = tgt_r;
    start_nxt     = start_r;
    mul_nxt       = mul_r;
    neg_nxt       = neg_r;
    acc_nxt       = acc_r;
    ramp_left_nxt = ramp_left_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    c_we = 1'b0; c_waddr = '0; c_wdata = '0; c_raddr = '0;
    h_we = 1'b0; h_waddr = '0; h_wdata = '0; h_raddr = '0;
    mul_a = '0;
    mul_b = '0;

    // output register drains
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // identity coefficients and zero history
      ST_CLEAR: begin
        c_we    = 1'b1;
        c_waddr = cnt_r;
        c_wdata = (cnt_r[3:0] < 4'(NCOEF) && is_b0(cnt_r[3:0])) ? ONE_Q20 : '0;
        h_we    = 1'b1;
        h_waddr = cnt_r[HIST_AW-1:0];
        h_wdata = '0;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(COEF_D - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          ch_nxt   = in_data.channel;
          x_nxt    = in_data.sample_in;
          band_nxt = '0;
          cnt_nxt  = '0;
          ph_nxt   = '0;
          case (op_t'(in_data.op))
            OP_LOAD: begin
              if (in_data.band < 2'(NUM_BANDS) && in_data.coeff_index < 3'd5) begin
                c_we    = 1'b1;
                c_waddr = {SET_STAGED, coef_idx(in_data.band, in_data.coeff_index)};
                c_wdata = in_data.coeff_value;
              end
            end
            OP_COMMIT: begin
              ramp_left_nxt = RAMP_W'(RAMP_SAMPLES);
              state_nxt     = ST_COPY_A;
            end
            OP_FILTER: begin
              if (4'(in_data.channel) < 4'(MAX_CHANNELS)) begin
                if (in_data.channel == 1'b0 && ramp_left_r != '0) begin
                  ramp_left_nxt = ramp_dec;
                  state_nxt     = (ramp_dec == '0) ? ST_SNAP : ST_RAMP;
                end else begin
                  state_nxt = ST_FILT;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      // set to set copy, read one word ahead of the write
      ST_COPY_A, ST_COPY_S, ST_SNAP: begin
        c_raddr = {cpy_src, cnt_r[3:0]};
        if (cnt_r != '0) begin
          c_we    = 1'b1;
          c_waddr = {cpy_dst, cpy_idx};
          c_wdata = c_rdata;
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(NCOEF)) begin
          cnt_nxt = '0;
          case (state_r)
            ST_COPY_A: state_nxt = ST_COPY_S;
            ST_COPY_S: state_nxt = ST_IDLE;
            default:   state_nxt = ST_FILT;
          endcase
        end
      end

      // one interpolation step over all coefficients
      ST_RAMP: begin
        case (ph_r)
          2'd0: c_raddr = {SET_TARGET, cnt_r[3:0]};
          2'd1: begin
            c_raddr = {SET_START, cnt_r[3:0]};
            tgt_nxt = c_rdata;
          end
          2'd2: begin
            start_nxt = c_rdata;
            mul_a     = 25'(tgt_r) - 25'(signed'(c_rdata));
            mul_b     = signed'(25'(ramp_k));
            mul_nxt   = prod;
          end
          default: begin
            c_we    = 1'b1;
            c_waddr = {SET_ACTIVE, cnt_r[3:0]};
            c_wdata = start_r + DATA_W'(mul_r >>> RAMP_LOG2);
            cnt_nxt = cnt_r + 6'd1;
            if (cnt_r == 6'(NCOEF - 1)) begin
              cnt_nxt   = '0;
              state_nxt = ST_FILT;
            end
          end
        endcase
        ph_nxt = ph_r + 2'd1;
      end

      // one biquad band: reads, products, accumulate, history write back
      ST_FILT: begin
        if (cnt_r <= 6'd4) begin
          c_raddr = {SET_ACTIVE, coef_idx(band_r, cnt_r[2:0])};
        end
        if (cnt_r >= 6'd1 && cnt_r <= 6'd4) begin
          h_raddr = {ch_r, band_r, 2'(cnt_r - 6'd1)};
        end
        if (cnt_r >= 6'd1 && cnt_r <= 6'd5) begin
          mul_a   = 25'(signed'(c_rdata));
          mul_b   = (cnt_r == 6'd1) ? 25'(x_r) : 25'(signed'(h_rdata));
          mul_nxt = prod;
          neg_nxt = (cnt_r >= 6'd4);
        end
        if (cnt_r == 6'd2) h0_nxt = h_rdata;
        if (cnt_r == 6'd4) h2_nxt = h_rdata;
        if (cnt_r >= 6'd2 && cnt_r <= 6'd6) begin
          acc_nxt = ((cnt_r == 6'd2) ? ACC_W'(0) : acc_r) +
                    (neg_r ? -ACC_W'(mul_r) : ACC_W'(mul_r));
        end
        case (cnt_r)
          6'd7: begin
            y_nxt   = y_sat;
            h_we    = 1'b1;
            h_waddr = {ch_r, band_r, 2'd0};
            h_wdata = x_r;
          end
          6'd8: begin
            h_we    = 1'b1;
            h_waddr = {ch_r, band_r, 2'd1};
            h_wdata = h0_r;
          end
          6'd9: begin
            h_we    = 1'b1;
            h_waddr = {ch_r, band_r, 2'd2};
            h_wdata = y_r;
          end
          6'd10: begin
            h_we    = 1'b1;
            h_waddr = {ch_r, band_r, 2'd3};
            h_wdata = h2_r;
          end
          default: begin
          end
        endcase
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd10) begin
          cnt_nxt  = '0;
          x_nxt    = y_r;
          band_nxt = band_r + 2'd1;
          if (band_r == 2'(NUM_BANDS - 1)) begin
            state_nxt = ST_OUT;
          end
        end
      end

      // hand the word to the output register
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt         = 1'b1;
          out_nxt.sample_out    = x_r;
          out_nxt.channel_out   = ch_r;
          state_nxt             = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      ph_r        <= '0;
      ramp_left_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ph_r        <= ph_nxt;
      ramp_left_r <= ramp_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    band_r  <= band_nxt;
    ch_r    <= ch_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    h0_r    <= h0_nxt;
    h2_r    <= h2_nxt;
    tgt_r   <= tgt_nxt;
    start_r <= start_nxt;
    mul_r   <= mul_nxt;
    neg_r   <= neg_nxt;
    acc_r   <= acc_nxt;
    out_r   <= out_nxt;
  end

endmodule
